[rtl/lpr_pkg.sv]
package lpr_pkg;

  // Fixed widths of the port fields
  localparam int PAGE_IN_W  = 8;
  localparam int FIDX_OUT_W = 3;
  localparam int CNT_OUT_W  = 16;
  localparam int CFG_W      = 4;

  localparam logic [CFG_W-1:0] CFG_FRAME_COUNT_RST = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } lpr_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // capture page and frame count, restart scan
    logic scan;         // advance lookup / victim scan by one frame
    logic take_hit;     // target is the matching frame
    logic take_empty;   // target is the lowest empty active frame
    logic take_victim;  // target is the oldest frame, fetch its page
    logic commit;       // write frame state, counters and result word
  } lpr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit_found;
    logic scan_done;
    logic has_empty;
  } lpr_stat_t;

endpackage

[rtl/lpr_ctrl.sv]
module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lpr_stat_t stat,
  output lpr_cmd_t  cmd,
  output logic      busy
);

  lpr_state_t state_r;
  lpr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat.hit_found || stat.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_LOOKUP: begin
        cmd.scan = 1'b1;
        // first match wins; otherwise fill an empty frame before evicting
        if (stat.hit_found) begin
          cmd.take_hit = 1'b1;
        end else if (stat.scan_done) begin
          if (stat.has_empty) begin
            cmd.take_empty = 1'b1;
          end else begin
            cmd.take_victim = 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/lpr_dp.sv]
module lpr_dp
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpr_cmd_t              cmd,
  output lpr_stat_t             stat,
  input  logic [CFG_W-1:0]      frame_count,
  input  logic [PAGE_IN_W-1:0]  in_page,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [FIDX_OUT_W-1:0] out_frame_index,
  output logic                  out_evicted_valid,
  output logic [PAGE_IN_W-1:0]  out_evicted_page,
  output logic [CNT_OUT_W-1:0]  out_fault_total,
  output logic [CNT_OUT_W-1:0]  out_reference_total
);

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam logic [FIDX_W-1:0] RANK_MAX = FIDX_W'(FRAMES - 1);

  // page store, read one frame per cycle
  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_r;
  logic [FIDX_W-1:0]    rd_addr;

  logic [FRAMES-1:0]    valid_r;
  logic [FIDX_W-1:0]    rank_r   [FRAMES];
  logic [FIDX_W-1:0]    rank_nxt [FRAMES];

  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     sc_r;
  logic [FIDX_W-1:0]    sc_idx;
  logic                 scan_live;
  logic                 rd_vld_r;
  logic [FIDX_W-1:0]    rd_idx_r;
  logic [FIDX_W-1:0]    best_rank_r;
  logic [FIDX_W-1:0]    best_idx_r;
  logic [FIDX_W-1:0]    tgt_r;
  logic                 hit_r;
  logic                 ev_r;
  logic                 match;
  logic                 has_empty;
  logic [FIDX_W-1:0]    empty_idx;
  logic [FIDX_W-1:0]    old_rank;

  logic [CNT_OUT_W-1:0]  fault_cnt_r;
  logic [CNT_OUT_W-1:0]  ref_cnt_r;
  logic                  out_valid_r;
  logic                  o_hit_r;
  logic [FIDX_OUT_W-1:0] o_fidx_r;
  logic                  o_ev_vld_r;
  logic [PAGE_IN_W-1:0]  o_ev_page_r;

  // zero means one frame, anything above the build depth means all frames
  always_comb begin
    if (frame_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (int'(frame_count) > FRAMES) begin
      n_clamp = CNT_W'(FRAMES);
    end else begin
      n_clamp = CNT_W'(frame_count);
    end
  end

  assign sc_idx    = sc_r[FIDX_W-1:0];
  assign scan_live = (sc_r < n_r);
  assign match     = rd_vld_r && valid_r[rd_idx_r] && (rd_data_r == page_r);
  assign rd_addr   = cmd.take_victim ? best_idx_r : sc_idx;
  assign old_rank  = rank_r[tgt_r];

  // lowest empty active frame
  always_comb begin
    has_empty = 1'b0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((i < int'(n_r)) && !valid_r[i]) begin
        has_empty = 1'b1;
        empty_idx = FIDX_W'(i);
      end
    end
  end

  assign stat.hit_found = match;
  assign stat.scan_done = !scan_live;
  assign stat.has_empty = has_empty;

  // recency update: target to rank zero, younger (or all, on a fault) age by one
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (cmd.commit) begin
        if (FIDX_W'(i) == tgt_r) begin
          rank_nxt[i] = '0;
        end else if ((i < int'(n_r)) && valid_r[i] &&
                     (!hit_r || (rank_r[i] < old_rank)) &&
                     (rank_r[i] != RANK_MAX)) begin
          rank_nxt[i] = rank_r[i] + FIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      mem[tgt_r] <= page_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r        <= '0;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      fault_cnt_r <= '0;
      ref_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      out_valid_r <= cmd.commit;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (cmd.load) begin
        sc_r     <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        if (scan_live) begin
          sc_r     <= sc_r + CNT_W'(1);
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        valid_r[tgt_r] <= 1'b1;
        if (ref_cnt_r != '1) begin
          ref_cnt_r <= ref_cnt_r + CNT_OUT_W'(1);
        end
        if (!hit_r && (fault_cnt_r != '1)) begin
          fault_cnt_r <= fault_cnt_r + CNT_OUT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r      <= PAGE_BITS'(in_page);
      n_r         <= n_clamp;
      best_rank_r <= '0;
      best_idx_r  <= '0;
    end else if (cmd.scan && scan_live) begin
      rd_idx_r <= sc_idx;
      if (rank_r[sc_idx] > best_rank_r) begin
        best_rank_r <= rank_r[sc_idx];
        best_idx_r  <= sc_idx;
      end
    end
    if (cmd.take_hit) begin
      tgt_r <= rd_idx_r;
      hit_r <= 1'b1;
      ev_r  <= 1'b0;
    end else if (cmd.take_empty) begin
      tgt_r <= empty_idx;
      hit_r <= 1'b0;
      ev_r  <= 1'b0;
    end else if (cmd.take_victim) begin
      tgt_r <= best_idx_r;
      hit_r <= 1'b0;
      ev_r  <= 1'b1;
    end
    if (cmd.commit) begin
      o_hit_r     <= hit_r;
      o_fidx_r    <= FIDX_OUT_W'(tgt_r);
      o_ev_vld_r  <= ev_r;
      o_ev_page_r <= ev_r ? PAGE_IN_W'(rd_data_r) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_frame_index     = o_fidx_r;
  assign out_evicted_valid   = o_ev_vld_r;
  assign out_evicted_page    = o_ev_page_r;
  assign out_fault_total     = fault_cnt_r;
  assign out_reference_total = ref_cnt_r;

endmodule

[rtl/lru_page_replacement.sv]
// Channel   Direction  Handshake               Word
// in_       input      start & !busy           in_page
// out_      output     out_valid (1 cycle)     hit, frame index, evicted page, totals
// cfg_      input      cfg_we                  cfg_wdata = frame count
//
// A word is looked up and then committed; its result shows in the out_valid cycle. The
// lookup walks the n active frames (at most FRAMES) of the page store one frame a cycle
// through its single read port, tracking the oldest frame on the way, and stops early on
// a hit; a commit state follows. The next word is accepted in the out_valid cycle.
// Reset (synchronous, rst_n low) clears valid bits, ranks and totals; frame count goes to 3.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAGE_IN_W-1:0]  in_page,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [FIDX_OUT_W-1:0] out_frame_index,
  output logic                  out_evicted_valid,
  output logic [PAGE_IN_W-1:0]  out_evicted_page,
  output logic [CNT_OUT_W-1:0]  out_fault_total,
  output logic [CNT_OUT_W-1:0]  out_reference_total
);

  logic [CFG_W-1:0] frame_count_r;
  lpr_cmd_t         cmd;
  lpr_stat_t        stat;

  // Hold the frame count; it is sampled when a word is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= CFG_FRAME_COUNT_RST;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  // Sequence load, scan, target pick and commit.
  lpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Frame store, ranks, totals and the result register.
  lpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .frame_count         (frame_count_r),
    .in_page             (in_page),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_frame_index     (out_frame_index),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_total     (out_fault_total),
    .out_reference_total (out_reference_total)
  );

  // A result word only appears once the controller is back to idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result word while busy");

  // An accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted word did not start a lookup");

  // A hit never evicts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("hit reported an eviction");

  // Without an eviction the evicted page reads zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page not zero");

endmodule
